/* hdl/ecm_pkg.sv */
// ----------------------------------------------------------------------------
// ecm_pkg: shared definitions for the escape count color map
// Widths, register indexes, reset values and derived constants used by the
// stream interfaces and the color map pipeline.
// ----------------------------------------------------------------------------
package ecm_pkg;

  // Escape count width and fixed-point fraction bits.
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned COLOR_W    = 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned RATE_W     = 13;
  localparam int unsigned OFFSET_W   = 10;
  localparam int unsigned CFG_DATA_W = RATE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOLID_RED    = 3'd0,
    REG_SOLID_GREEN  = 3'd1,
    REG_SOLID_BLUE   = 3'd2,
    REG_CYCLE_RATE   = 3'd3,
    REG_CYCLE_OFFSET = 3'd4
  } cfg_reg_e;

  // Phase length L = 2^24 / rate, Q12.8, saturated to 20 bits.
  localparam int unsigned L_TOP = 24;
  localparam int unsigned L_W   = 20;
  localparam logic [L_W-1:0] LEN_MAX = '1;

  // Three phase lengths and the scaled offset.
  localparam int unsigned D3_W  = L_W + 2;
  localparam int unsigned OFF_W = L_W + OFFSET_W - FRAC_BITS;

  // Ramp position before the modulo.
  localparam int unsigned VAL_W =
    ((COUNT_BITS + FRAC_BITS > OFF_W) ? COUNT_BITS + FRAC_BITS : OFF_W) + 1;

  // Reciprocal of 3L scaled by 2^VAL_W; 3L is always above 2^12.
  localparam int unsigned M1_W = VAL_W - 12;

  // Position times 255 and the reciprocal of L scaled by 2^N_W.
  localparam int unsigned N_W  = L_W + COLOR_W;
  localparam int unsigned M2_W = N_W - 10;

  // Serial divider sizes.
  localparam int unsigned DQ_W  = ((VAL_W > N_W) ? VAL_W : N_W) + 1;
  localparam int unsigned CNT_W = $clog2(DQ_W);

  // Reset values of registers and the values derived from them.
  localparam logic [COLOR_W-1:0]  SOLID_RED_RST    = 8'd255;
  localparam logic [COLOR_W-1:0]  SOLID_GREEN_RST  = 8'd0;
  localparam logic [COLOR_W-1:0]  SOLID_BLUE_RST   = 8'd0;
  localparam logic [RATE_W-1:0]   CYCLE_RATE_RST   = 13'd256;
  localparam logic [OFFSET_W-1:0] CYCLE_OFFSET_RST = 10'd0;

  localparam longint unsigned L_RST_VAL = (64'd1 << L_TOP) / 64'd256;
  localparam logic [L_W-1:0]  L_RST  = L_W'(L_RST_VAL);
  localparam logic [D3_W-1:0] D3_RST = D3_W'(3 * L_RST_VAL);
  localparam logic [M1_W-1:0] M1_RST = M1_W'((64'd1 << VAL_W) / (3 * L_RST_VAL));
  localparam logic [M2_W-1:0] M2_RST = M2_W'((64'd1 << N_W) / L_RST_VAL);

  // Ramp phases.
  typedef enum logic [1:0] {
    PH_RG = 2'd0,
    PH_GB = 2'd1,
    PH_BR = 2'd2
  } phase_e;

  // Pipeline depth including the output register.
  localparam int unsigned NSTG = 12;

endpackage

/* hdl/ecm_in_if.sv */
// ----------------------------------------------------------------------------
// ecm_in_if: escape count input channel
// Valid/ready channel carrying one iteration count per item.
// ----------------------------------------------------------------------------
interface ecm_in_if import ecm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] iteration_count;

  modport source (output valid, output iteration_count, input ready);
  modport sink   (input valid, input iteration_count, output ready);
endinterface

/* hdl/ecm_out_if.sv */
// ----------------------------------------------------------------------------
// ecm_out_if: pixel color output channel
// Valid/ready channel carrying one RGB color per item.
// ----------------------------------------------------------------------------
interface ecm_out_if import ecm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* hdl/escape_count_color_map_top.sv */
// ----------------------------------------------------------------------------
// escape_count_color_map_top: escape count to RGB color map
// Turns one escape iteration count per item into black, a solid or a cycling color.
// ----------------------------------------------------------------------------
// The block takes one iteration count per clock while the output does not stall
// and no setup pass runs, and returns its color through a twelve-stage pipeline;
// every stage stalls on its own, so bubbles close up while a result waits at the
// output. A count of zero is black, a non-zero solid color register gives that
// solid color, and with all three solid registers at zero a red-green-blue ramp
// of phase length L = 2^24 / cycle_rate (Q12.8) is used. Writing cycle_rate or
// cycle_offset starts a setup pass in a shared one-bit-per-cycle divider that
// derives L, the scaled offset and two reciprocals; the input is not ready
// during that pass. Writes to the solid color registers take effect at once.
// ----------------------------------------------------------------------------
module escape_count_color_map_top import ecm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ecm_in_if.sink                in_i,
  ecm_out_if.source             out_o
);

  // Setup sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_START  = 6'b000010,
    ST_DIV_L  = 6'b000100,
    ST_OFF    = 6'b001000,
    ST_DIV_M1 = 6'b010000,
    ST_DIV_M2 = 6'b100000
  } setup_state_e;

  // Per-item flags carried down the pipeline.
  typedef struct packed {
    logic zero;
    logic solid;
  } pix_flags_t;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [COLOR_W-1:0]  solid_red_q, solid_green_q, solid_blue_q;
  logic [RATE_W-1:0]   rate_q;
  logic [OFFSET_W-1:0] offset_q;
  logic                setup_req;

  assign setup_req = cfg_we_i &&
                     (cfg_idx_i == REG_CYCLE_RATE || cfg_idx_i == REG_CYCLE_OFFSET);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      solid_red_q   <= SOLID_RED_RST;
      solid_green_q <= SOLID_GREEN_RST;
      solid_blue_q  <= SOLID_BLUE_RST;
      rate_q        <= CYCLE_RATE_RST;
      offset_q      <= CYCLE_OFFSET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SOLID_RED:    solid_red_q   <= cfg_data_i[COLOR_W-1:0];
        REG_SOLID_GREEN:  solid_green_q <= cfg_data_i[COLOR_W-1:0];
        REG_SOLID_BLUE:   solid_blue_q  <= cfg_data_i[COLOR_W-1:0];
        REG_CYCLE_RATE:   rate_q        <= cfg_data_i[RATE_W-1:0];
        REG_CYCLE_OFFSET: offset_q      <= cfg_data_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Setup sequencer. One restoring divider computes, in turn,
  // L = 2^24 / rate, M1 = 2^VAL_W / 3L and M2 = 2^N_W / L. The dividend is a
  // single power of two, so the only bit brought in is the first one.
  // --------------------------------------------------------------------------
  setup_state_e       state_q, state_d;
  logic [L_W-1:0]     len_q;
  logic [OFF_W-1:0]   off_q;
  logic [D3_W-1:0]    d3_q;
  logic [M1_W-1:0]    m1_q;
  logic [M2_W-1:0]    m2_q;

  logic [D3_W-1:0]    div_d_q;
  logic [D3_W-1:0]    div_rem_q, div_rem_d;
  logic [DQ_W-1:0]    div_quo_q, div_quo_d;
  logic [CNT_W-1:0]   div_cnt_q;
  logic               div_first_q;
  logic [D3_W:0]      div_sh, div_sub;
  logic               div_ge, div_last;
  logic [L_W-1:0]     len_sat;
  logic [D3_W-1:0]    d3_calc;
  logic [L_W+OFFSET_W-1:0] off_prod;

  always_comb begin
    div_sh    = {div_rem_q, div_first_q};
    div_sub   = div_sh - {1'b0, div_d_q};
    div_ge    = div_sh >= {1'b0, div_d_q};
    div_rem_d = div_ge ? div_sub[D3_W-1:0] : div_sh[D3_W-1:0];
    div_quo_d = {div_quo_q[DQ_W-2:0], div_ge};
    div_last  = (div_cnt_q == '0);
    // A rate of zero or below 17 gives a quotient beyond 20 bits.
    len_sat   = (div_quo_d > DQ_W'(LEN_MAX)) ? LEN_MAX : div_quo_d[L_W-1:0];
    d3_calc   = D3_W'({len_q, 1'b0}) + D3_W'(len_q);
    off_prod  = len_q * offset_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   state_d = ST_IDLE;
      ST_START:  state_d = ST_DIV_L;
      ST_DIV_L:  if (div_last) state_d = ST_OFF;
      ST_OFF:    state_d = ST_DIV_M1;
      ST_DIV_M1: if (div_last) state_d = ST_DIV_M2;
      ST_DIV_M2: if (div_last) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
    // A new rate or offset restarts the whole pass.
    if (setup_req) begin
      state_d = ST_START;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= L_RST;
      off_q       <= '0;
      d3_q        <= D3_RST;
      m1_q        <= M1_RST;
      m2_q        <= M2_RST;
      div_d_q     <= '0;
      div_rem_q   <= '0;
      div_quo_q   <= '0;
      div_cnt_q   <= '0;
      div_first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_START: begin
          div_d_q     <= D3_W'(rate_q);
          div_rem_q   <= '0;
          div_quo_q   <= '0;
          div_first_q <= 1'b1;
          div_cnt_q   <= CNT_W'(L_TOP);
        end
        ST_DIV_L, ST_DIV_M1, ST_DIV_M2: begin
          div_rem_q   <= div_rem_d;
          div_quo_q   <= div_quo_d;
          div_first_q <= 1'b0;
          div_cnt_q   <= div_cnt_q - 1'b1;
          if (div_last) begin
            if (state_q == ST_DIV_L) begin
              len_q <= len_sat;
            end
            if (state_q == ST_DIV_M1) begin
              m1_q        <= div_quo_d[M1_W-1:0];
              div_d_q     <= D3_W'(len_q);
              div_rem_q   <= '0;
              div_quo_q   <= '0;
              div_first_q <= 1'b1;
              div_cnt_q   <= CNT_W'(N_W);
            end
            if (state_q == ST_DIV_M2) begin
              m2_q <= div_quo_d[M2_W-1:0];
            end
          end
        end
        ST_OFF: begin
          off_q       <= off_prod[L_W+OFFSET_W-1:FRAC_BITS];
          d3_q        <= d3_calc;
          div_d_q     <= d3_calc;
          div_rem_q   <= '0;
          div_quo_q   <= '0;
          div_first_q <= 1'b1;
          div_cnt_q   <= CNT_W'(VAL_W);
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pixel pipeline. Each stage moves when it is empty or the next one moves.
  //   1  position = count * 256 + offset
  //   2  position times the reciprocal of 3L
  //   3  quotient estimate times 3L
  //   4  first remainder (below 6L)
  //   5  corrected remainder (position modulo 3L)
  //   6  phase and position t inside the phase
  //   7  n = 255 * t
  //   8  n times the reciprocal of L, giving an estimate of n / L
  //   9  estimate times L
  //  10  first remainder (below 2L)
  //  11  corrected quotient b and whether the remainder is non-zero
  //  12  output register: the falling channel is 255 - b, less one when the
  //      remainder is non-zero, and the rising channel is b
  // --------------------------------------------------------------------------
  logic [NSTG:1] v_q;
  logic [NSTG:1] en;
  logic          in_fire;

  always_comb begin
    en[NSTG] = !v_q[NSTG] || out_o.ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = (state_q == ST_IDLE) && en[1];
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_fire;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  pix_flags_t            fl_q [1:NSTG-1];
  phase_e                ph_q [6:NSTG-1];
  logic [VAL_W-1:0]      val1_q, val2_q, val3_q;
  logic [VAL_W+M1_W-1:0] pa2_q;
  logic [VAL_W-1:0]      qd3_q;
  logic [D3_W:0]         rem4_q;
  logic [D3_W-1:0]       rm5_q;
  logic [L_W-1:0]        t6_q;
  logic [N_W-1:0]        n7_q, n8_q, n9_q, bl9_q;
  logic [COLOR_W-1:0]    b8_q, b9_q, b10_q, b11_q;
  logic [L_W:0]          r10_q;
  logic                  nz11_q;
  logic [COLOR_W-1:0]    red_q, green_q, blue_q;

  pix_flags_t            fl_in;
  logic [M1_W+D3_W-1:0]  qd_full;
  logic [VAL_W-1:0]      rem_full;
  logic [D3_W:0]         rem_sub;
  logic                  ph_ge1, ph_ge2;
  logic [D3_W-1:0]       ph_base, t_full;
  logic [N_W+M2_W-1:0]   pb_full;
  logic [N_W-1:0]        bl_full, r_full;
  logic [L_W:0]          r_sub;
  logic                  r_ge;
  logic [COLOR_W-1:0]    fall_c;

  always_comb begin
    fl_in.zero  = (in_i.iteration_count == '0);
    fl_in.solid = (solid_red_q != '0) || (solid_green_q != '0) || (solid_blue_q != '0);

    qd_full  = pa2_q[VAL_W+M1_W-1:VAL_W] * d3_q;
    rem_full = val3_q - qd3_q;
    rem_sub  = rem4_q - {1'b0, d3_q};

    ph_ge2  = rm5_q >= D3_W'({len_q, 1'b0});
    ph_ge1  = rm5_q >= D3_W'(len_q);
    ph_base = ph_ge2 ? D3_W'({len_q, 1'b0}) : (ph_ge1 ? D3_W'(len_q) : '0);
    t_full  = rm5_q - ph_base;

    pb_full = n7_q * m2_q;
    bl_full = b8_q * len_q;
    r_full  = n9_q - bl9_q;

    r_ge    = r10_q >= {1'b0, len_q};
    r_sub   = r10_q - {1'b0, len_q};

    fall_c  = 8'd255 - b11_q - COLOR_W'(nz11_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      val1_q <= VAL_W'({in_i.iteration_count, FRAC_BITS'(0)}) + VAL_W'(off_q);
      fl_q[1] <= fl_in;
    end
    for (int k = 2; k <= NSTG - 1; k++) begin
      if (en[k]) begin
        fl_q[k] <= fl_q[k-1];
      end
    end
    if (en[2]) begin
      pa2_q  <= val1_q * m1_q;
      val2_q <= val1_q;
    end
    if (en[3]) begin
      qd3_q  <= qd_full[VAL_W-1:0];
      val3_q <= val2_q;
    end
    if (en[4]) begin
      rem4_q <= rem_full[D3_W:0];
    end
    if (en[5]) begin
      rm5_q <= (rem4_q >= {1'b0, d3_q}) ? rem_sub[D3_W-1:0] : rem4_q[D3_W-1:0];
    end
    if (en[6]) begin
      t6_q    <= t_full[L_W-1:0];
      ph_q[6] <= ph_ge2 ? PH_BR : (ph_ge1 ? PH_GB : PH_RG);
    end
    for (int k = 7; k <= NSTG - 1; k++) begin
      if (en[k]) begin
        ph_q[k] <= ph_q[k-1];
      end
    end
    if (en[7]) begin
      n7_q <= {t6_q, COLOR_W'(0)} - N_W'(t6_q);
    end
    if (en[8]) begin
      b8_q <= pb_full[N_W+COLOR_W-1:N_W];
      n8_q <= n7_q;
    end
    if (en[9]) begin
      bl9_q <= bl_full;
      b9_q  <= b8_q;
      n9_q  <= n8_q;
    end
    if (en[10]) begin
      r10_q <= r_full[L_W:0];
      b10_q <= b9_q;
    end
    if (en[11]) begin
      b11_q  <= b10_q + COLOR_W'(r_ge);
      nz11_q <= r_ge ? (r10_q != {1'b0, len_q}) : (r10_q != '0);
    end
    if (en[NSTG]) begin
      if (fl_q[NSTG-1].zero) begin
        red_q   <= '0;
        green_q <= '0;
        blue_q  <= '0;
      end else if (fl_q[NSTG-1].solid) begin
        red_q   <= solid_red_q;
        green_q <= solid_green_q;
        blue_q  <= solid_blue_q;
      end else begin
        case (ph_q[NSTG-1])
          PH_RG: begin
            red_q   <= fall_c;
            green_q <= b11_q;
            blue_q  <= '0;
          end
          PH_GB: begin
            red_q   <= '0;
            green_q <= fall_c;
            blue_q  <= b11_q;
          end
          PH_BR: begin
            red_q   <= b11_q;
            green_q <= '0;
            blue_q  <= fall_c;
          end
          default: begin
            red_q   <= '0;
            green_q <= '0;
            blue_q  <= '0;
          end
        endcase
      end
    end
  end

  assign out_o.valid = v_q[NSTG];
  assign out_o.red   = red_q;
  assign out_o.green = green_q;
  assign out_o.blue  = blue_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // One correction step is enough to bring the position below 3L.
  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] |-> rm5_q < d3_q)
    else $error("position modulo 3L out of range");

  // The reciprocal estimate of n / L is never more than one short.
  a_div_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[10] |-> r10_q < {len_q, 1'b0})
    else $error("ramp quotient estimate off by more than one");

  // A rising channel inside a phase never reaches full scale.
  a_ramp_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[11] |-> b11_q != 8'hFF)
    else $error("ramp value reached full scale");

  // The setup pass only starts on a rate or offset write.
  a_setup_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !setup_req) |=> state_q == ST_IDLE)
    else $error("setup pass started without a write");

endmodule
